### design/bphef_pkg.sv
// bphef_pkg: shared codes and constants for the battery peak-hold EMA filter.
// Used by battery_peak_hold_ema_filter_core and bphef_check; no dependencies.

package bphef_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_SETTLE_DEADLINE = 3'd0;
  localparam cfg_index_t CFG_BATTERY_OFFSET  = 3'd1;
  localparam cfg_index_t CFG_SCAN_ENABLED    = 3'd2;
  localparam cfg_index_t CFG_MIN_INTERVAL    = 3'd3;
  localparam cfg_index_t CFG_WINDOW          = 3'd4;
  localparam cfg_index_t CFG_AVERAGE_GAIN    = 3'd5;

  typedef logic [1:0] scan_cmd_t;
  localparam scan_cmd_t SCAN_NONE    = 2'd0;
  localparam scan_cmd_t SCAN_SUSPEND = 2'd1;
  localparam scan_cmd_t SCAN_RESTORE = 2'd2;
  localparam scan_cmd_t SCAN_INVALID = 2'd3;

  typedef logic [1:0] usb_state_t;
  localparam usb_state_t USB_OFF     = 2'd0;
  localparam usb_state_t USB_ON      = 2'd1;
  localparam usb_state_t USB_UNKNOWN = 2'd2;

  localparam logic [11:0] OFFSET_RESET      = 12'd2176;
  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd250;
  localparam logic [15:0] WINDOW_RESET      = 16'd2000;
  localparam logic [15:0] GAIN_RESET        = 16'd22938;
  localparam int          GAIN_FRAC_BITS    = 16;

  localparam int S_TDATA_BITS = 56;
  localparam int M_TDATA_BITS = 24;

endpackage

### design/battery_peak_hold_ema_filter_core.sv
// Path: an accepted input word is held in the input register, then its result word in the result register.
// Throughput: one word per cycle unless m_tready stalls the result; a dropped sample produces no result word.
// The critical path is the combinational EMA fold: offset add, peak compare, 16-bit gain multiply.
// Reset (rst, synchronous, active high) clears the pipeline, the filter state and the config
// registers to their defaults; s_tready and cfg_ready are low while rst is high.
// Depends on bphef_pkg.

module battery_peak_hold_ema_filter_core
  import bphef_pkg::*;
#(
  parameter int VOLT_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [S_TDATA_BITS-1:0]  s_tdata,   // now_ms[31:0], rail_volts[47:32], asleep[48]
  input  logic                     s_tuser,   // usb_powered
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [M_TDATA_BITS-1:0]  m_tdata,   // battery_volts[15:0], scan_command[17:16],
                                              // average_updated[18]
  output logic                     m_tuser,   // on_usb
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int VB = VOLT_BITS;
  localparam int TB = TIME_BITS;

  typedef logic [VB-1:0] volt_t;
  typedef logic [TB-1:0] tstamp_t;

  // config registers
  tstamp_t     settle_deadline;
  logic [11:0] battery_offset;
  logic        scan_enabled;
  logic [15:0] min_interval;
  logic [15:0] window_len;
  logic [15:0] average_gain;

  // input register
  logic    in_valid;
  tstamp_t in_now;
  logic    in_usb;
  volt_t   in_rail;
  logic    in_asleep;

  // filter state
  tstamp_t    last_accept;
  tstamp_t    window_start;
  volt_t      window_peak;
  volt_t      running_average;
  usb_state_t previous_usb;
  volt_t      reported_volts;

  tstamp_t    window_start_next;
  volt_t      window_peak_next;
  volt_t      running_average_next;
  volt_t      reported_volts_next;
  scan_cmd_t  cmd;
  logic       updated;

  // result register
  logic [15:0] out_volts;
  logic        out_usb;
  scan_cmd_t   out_cmd;
  logic        out_updated;

  logic       drop;
  logic       advance;
  tstamp_t    since;
  tstamp_t    to_deadline;
  tstamp_t    win_age;
  tstamp_t    start_eff;
  logic [VB:0] offset_sum;
  volt_t      v_bat;
  volt_t      peak_eff;
  volt_t      avg_eff;
  logic       peak_ge;
  volt_t      mag;
  logic [VB+15:0] prod;
  volt_t      step;
  volt_t      avg_fold;
  logic       fold;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_deadline <= '0;
      battery_offset  <= OFFSET_RESET;
      scan_enabled    <= 1'b0;
      min_interval    <= MIN_INTERVAL_RESET;
      window_len      <= WINDOW_RESET;
      average_gain    <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SETTLE_DEADLINE: settle_deadline <= TB'(cfg_data);
        CFG_BATTERY_OFFSET:  battery_offset  <= cfg_data[11:0];
        CFG_SCAN_ENABLED:    scan_enabled    <= cfg_data[0];
        CFG_MIN_INTERVAL:    min_interval    <= cfg_data[15:0];
        CFG_WINDOW:          window_len      <= cfg_data[15:0];
        CFG_AVERAGE_GAIN:    average_gain    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // gating and drop tests
  always_comb begin
    since       = in_now - last_accept;
    to_deadline = in_now - settle_deadline;
    drop        = (since < TB'(min_interval)) || to_deadline[TB-1];
    advance     = in_valid && (drop || !m_tvalid || m_tready);
  end

  // battery path and EMA fold
  always_comb begin
    offset_sum = {1'b0, in_rail} + (VB+1)'(battery_offset);
    v_bat      = offset_sum[VB] ? '1 : offset_sum[VB-1:0];
    peak_eff   = (v_bat > window_peak) ? v_bat : window_peak;
    start_eff  = (window_start == '0) ? in_now : window_start;
    avg_eff    = (running_average == '0) ? v_bat : running_average;
    win_age    = in_now - start_eff;
    fold       = win_age >= TB'(window_len);
    peak_ge    = peak_eff >= avg_eff;
    mag        = peak_ge ? (peak_eff - avg_eff) : (avg_eff - peak_eff);
    prod       = (VB+16)'(mag) * (VB+16)'(average_gain)
                 + (VB+16)'(1 << (GAIN_FRAC_BITS - 1));
    step       = prod[VB+15:GAIN_FRAC_BITS];
    avg_fold   = peak_ge ? (avg_eff + step) : (avg_eff - step);
  end

  always_comb begin
    cmd = SCAN_NONE;
    if (previous_usb != USB_ON && in_usb) begin
      cmd = SCAN_SUSPEND;
    end else if (previous_usb != USB_OFF && !in_usb) begin
      if (scan_enabled && !in_asleep) begin
        cmd = SCAN_RESTORE;
      end
    end

    window_start_next    = window_start;
    window_peak_next     = window_peak;
    running_average_next = running_average;
    reported_volts_next  = reported_volts;
    updated              = 1'b0;
    if (in_usb) begin
      reported_volts_next  = in_rail;
      window_peak_next     = '0;
      window_start_next    = in_now;
      running_average_next = '0;
    end else begin
      window_peak_next  = peak_eff;
      window_start_next = start_eff;
      if (running_average == '0) begin
        running_average_next = v_bat;
        reported_volts_next  = v_bat;
        updated              = 1'b1;
      end
      if (fold) begin
        running_average_next = avg_fold;
        reported_volts_next  = avg_fold;
        window_peak_next     = '0;
        window_start_next    = in_now;
        updated              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now    <= TB'(s_tdata[31:0]);
      in_rail   <= VB'(s_tdata[47:32]);
      in_asleep <= s_tdata[48];
      in_usb    <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accept     <= '0;
      window_start    <= '0;
      window_peak     <= '0;
      running_average <= '0;
      previous_usb    <= USB_UNKNOWN;
      reported_volts  <= '0;
    end else if (advance && !drop) begin
      last_accept     <= in_now;
      window_start    <= window_start_next;
      window_peak     <= window_peak_next;
      running_average <= running_average_next;
      previous_usb    <= in_usb ? USB_ON : USB_OFF;
      reported_volts  <= reported_volts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && !drop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !drop) begin
      out_volts   <= 16'(reported_volts_next);
      out_usb     <= in_usb;
      out_cmd     <= cmd;
      out_updated <= updated;
    end
  end

  assign m_tdata = {5'b0, out_updated, out_cmd, out_volts};
  assign m_tuser = out_usb;

endmodule

### design/bphef_check.sv
// bphef_props: port-level assertions for battery_peak_hold_ema_filter_core, plus its bind.
// Depends on bphef_pkg.

module bphef_props
  import bphef_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [S_TDATA_BITS-1:0]  s_tdata,
  input logic                     s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [M_TDATA_BITS-1:0]  m_tdata,
  input logic                     m_tuser,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input cfg_index_t               cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:16] != SCAN_INVALID))
    else $error("invalid scan command");

  a_usb_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser ? (!m_tdata[18] && m_tdata[17:16] != SCAN_RESTORE)
                          : (m_tdata[17:16] != SCAN_SUSPEND)))
    else $error("scan command or update flag inconsistent with power source");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without an input word two cycles earlier");

endmodule

bind battery_peak_hold_ema_filter_core bphef_props u_bphef_props (.*);
